>>> hw/rtl/nnr_pkg.sv
// ---------------------------------------------------------------------------
// nnr_pkg: shared types, codes and helpers of the image rotator
// Holds the state encoding, request and register codes, pixel widths and
// the elaboration-time sine table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package nnr_pkg;

   localparam int PIX_W      = 24;
   localparam int COORD_W    = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int ROT_W      = 9;
   localparam int SRC_REG_W  = 9;
   localparam int DST_REG_W  = 10;
   localparam int TRIG_IDX_W = 7;

   localparam logic [ROT_W-1:0] DEG_90  = 9'd90;
   localparam logic [ROT_W-1:0] DEG_180 = 9'd180;
   localparam logic [ROT_W-1:0] DEG_270 = 9'd270;
   localparam logic [ROT_W-1:0] DEG_360 = 9'd360;

   localparam logic [7:0] WHITE_LEVEL = 8'd255;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } nnr_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROTATION   = 3'd0,
      CSR_SRC_WIDTH  = 3'd1,
      CSR_SRC_HEIGHT = 3'd2,
      CSR_DST_WIDTH  = 3'd3,
      CSR_DST_HEIGHT = 3'd4
   } nnr_csr_type;

   typedef enum logic [2:0] {
      NNR_IDLE,
      NNR_MUL,
      NNR_SUM,
      NNR_CHECK,
      NNR_READ
   } nnr_state_type;

   typedef struct packed {
      logic [TRIG_IDX_W-1:0] idx;
      logic                  neg;
   } nnr_trig_sel_type;

   // quarter-wave lookup for an angle already below 360
   function automatic nnr_trig_sel_type nnr_trig_sel(input logic [ROT_W-1:0] a);
      nnr_trig_sel_type sel;
      logic [ROT_W-1:0] d;
      d = '0;
      if (a <= DEG_90) begin
         d = a;
         sel.neg = 1'b0;
      end else if (a <= DEG_180) begin
         d = DEG_180 - a;
         sel.neg = 1'b0;
      end else if (a <= DEG_270) begin
         d = a - DEG_180;
         sel.neg = 1'b1;
      end else begin
         d = DEG_360 - a;
         sel.neg = 1'b1;
      end
      sel.idx = d[TRIG_IDX_W-1:0];
      return sel;
   endfunction

   // q30 product of a series term with x^2, rounded
   function automatic longint unsigned nnr_taylor_mul(input longint unsigned term,
                                                      input longint unsigned x2);
      return (term * x2 + (64'd1 << 29)) >> 30;
   endfunction

   // round(sin(k deg) * 2^frac) from a q30 taylor series, evaluated at elaboration
   function automatic longint unsigned nnr_quarter_sin(input int k, input int frac);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      x = (longint'(unsigned'(k)) * PI_Q30 + 64'd90) / 64'd180;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      // divisors are (2n)(2n+1) for n = 1..12, odd steps subtract
      term = nnr_taylor_mul(term, x2) / 64'd6;
      sum = sum - longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd20;
      sum = sum + longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd42;
      sum = sum - longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd72;
      sum = sum + longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd110;
      sum = sum - longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd156;
      sum = sum + longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd210;
      sum = sum - longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd272;
      sum = sum + longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd342;
      sum = sum - longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd420;
      sum = sum + longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd506;
      sum = sum - longint'(term);
      term = nnr_taylor_mul(term, x2) / 64'd600;
      sum = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = longint'(sum);
      return (v + (64'd1 << (29 - frac))) >> (30 - frac);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nearest_neighbor_image_rotator_core.sv
// ---------------------------------------------------------------------------
// nearest_neighbor_image_rotator_core: nearest-neighbour image rotation
// Holds a 24-bit source image and answers fetches of the rotated image.
// ---------------------------------------------------------------------------
// usage
//   req channel: tuser is the opcode (0 load, 1 fetch). a load transaction
//   writes one source pixel at (col,row). a fetch names an output point and
//   yields one rsp transaction.
//   rsp channel: pixel in tdata, tuser high when the mapped point is off the
//   source image and the pixel is white.
//   csr channel: register writes by index, always ready; write only while
//   no fetch is in flight.
//   a fetch walks five steps (register, multiply, sum, bounds check with
//   the pixel memory read, deliver): rsp_tvalid rises from the output
//   register in the same cycle that the control is back in idle and can
//   take the next request. loads run at one per cycle while no fetch is
//   in its steps. the control walks one fetch at a time through the single
//   multiply/sum path and the one read port of the pixel memory.
//   the result sits in an output register, so a new request is taken while
//   it waits; a stalled receiver holds a second fetch in its delivery step.
//   reset clears control state and the registers to their defaults; the
//   pixel memory is not cleared and must be loaded before it is fetched.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_rotator_core
   import nnr_pkg::*;
#(
   parameter int MAX_SRC_SIDE   = 256,
   parameter int MAX_DST_SIDE   = 512,
   parameter int TRIG_FRAC_BITS = 15
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // col [8:0], row [17:9], blue_in [25:18], green_in [33:26], red_in [41:34]
   input  wire logic [47:0]           req_tdata,
   // opcode [0]
   input  wire logic [0:0]            req_tuser,
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // blue_out [7:0], green_out [15:8], red_out [23:16]
   output logic [23:0]                rsp_tdata,
   // outside [0]
   output logic [0:0]                 rsp_tuser,
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AB    = $clog2(MAX_SRC_SIDE);
   localparam int DEPTH = 1 << (2 * AB);
   localparam int SB    = $clog2(MAX_SRC_SIDE + 1);
   localparam int DB    = $clog2(MAX_DST_SIDE + 1);
   localparam int DXW   = ((DB > COORD_W + 1) ? DB : COORD_W + 1) + 2;
   localparam int TW    = TRIG_FRAC_BITS + 2;
   localparam int PW    = DXW + TW;
   localparam int OFSW  = SB + TRIG_FRAC_BITS + 1;
   localparam int SUMW  = ((PW > OFSW) ? PW : OFSW) + 2;
   localparam int IXW   = SUMW - 2 - TRIG_FRAC_BITS;

   // register file
   logic [ROT_W-1:0]     rot_ff;
   logic [SRC_REG_W-1:0] src_w_ff;
   logic [SRC_REG_W-1:0] src_h_ff;
   logic [DST_REG_W-1:0] dst_w_ff;
   logic [DST_REG_W-1:0] dst_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff   <= '0;
         src_w_ff <= SRC_REG_W'(256);
         src_h_ff <= SRC_REG_W'(256);
         dst_w_ff <= DST_REG_W'(256);
         dst_h_ff <= DST_REG_W'(256);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROTATION:   rot_ff   <= csr_wdata[ROT_W-1:0];
            CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SRC_REG_W-1:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SRC_REG_W-1:0];
            CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[DST_REG_W-1:0];
            CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[DST_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // saturated sizes
   logic [SB-1:0] sw_sat;
   logic [SB-1:0] sh_sat;
   logic [DB-1:0] dw_sat;
   logic [DB-1:0] dh_sat;

   assign sw_sat = (src_w_ff > MAX_SRC_SIDE) ? SB'(MAX_SRC_SIDE) : SB'(src_w_ff);
   assign sh_sat = (src_h_ff > MAX_SRC_SIDE) ? SB'(MAX_SRC_SIDE) : SB'(src_h_ff);
   assign dw_sat = (dst_w_ff > MAX_DST_SIDE) ? DB'(MAX_DST_SIDE) : DB'(dst_w_ff);
   assign dh_sat = (dst_h_ff > MAX_DST_SIDE) ? DB'(MAX_DST_SIDE) : DB'(dst_h_ff);

   // sine rom, one quarter wave
   logic [TRIG_FRAC_BITS:0] sin_rom [0:90];

   for (genvar k = 0; k <= 90; k++) begin : g_sin_rom
      localparam longint unsigned QV = nnr_quarter_sin(k, TRIG_FRAC_BITS);
      assign sin_rom[k] = QV[TRIG_FRAC_BITS:0];
   end

   logic [ROT_W-1:0]        ang;
   logic [ROT_W-1:0]        ang_cos;
   nnr_trig_sel_type        sin_sel;
   nnr_trig_sel_type        cos_sel;
   logic signed [TW-1:0]    sin_mag;
   logic signed [TW-1:0]    cos_mag;
   logic signed [TW-1:0]    sin_in;
   logic signed [TW-1:0]    cos_in;
   logic signed [TW-1:0]    sin_ff;
   logic signed [TW-1:0]    cos_ff;

   assign ang     = (rot_ff >= DEG_360) ? rot_ff - DEG_360 : rot_ff;
   assign ang_cos = (ang >= DEG_270) ? ang - DEG_270 : ang + DEG_90;
   assign sin_sel = nnr_trig_sel(ang);
   assign cos_sel = nnr_trig_sel(ang_cos);
   assign sin_mag = $signed(TW'(sin_rom[sin_sel.idx]));
   assign cos_mag = $signed(TW'(sin_rom[cos_sel.idx]));
   assign sin_in  = sin_sel.neg ? -sin_mag : sin_mag;
   assign cos_in  = cos_sel.neg ? -cos_mag : cos_mag;

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   // request fields
   logic [COORD_W-1:0] req_col;
   logic [COORD_W-1:0] req_row;
   logic [PIX_W-1:0]   req_pix;

   assign req_col = req_tdata[8:0];
   assign req_row = req_tdata[17:9];
   assign req_pix = req_tdata[41:18];

   // datapath registers
   logic signed [DXW-1:0]  dx_in, dx_ff;
   logic signed [DXW-1:0]  dy_in, dy_ff;
   logic signed [PW-1:0]   p_xc_in, p_xc_ff;
   logic signed [PW-1:0]   p_ys_in, p_ys_ff;
   logic signed [PW-1:0]   p_xs_in, p_xs_ff;
   logic signed [PW-1:0]   p_yc_in, p_yc_ff;
   logic signed [SUMW-1:0] x_sum_in, x_sum_ff;
   logic signed [SUMW-1:0] y_sum_in, y_sum_ff;
   logic                   outside_in, outside_ff;

   assign dx_in = $signed(DXW'({req_col, 1'b0})) - $signed(DXW'(dw_sat)) + $signed(DXW'(1));
   assign dy_in = $signed(DXW'({req_row, 1'b0})) - $signed(DXW'(dh_sat)) + $signed(DXW'(1));

   assign p_xc_in = dx_ff * cos_ff;
   assign p_ys_in = dy_ff * sin_ff;
   assign p_xs_in = dx_ff * sin_ff;
   assign p_yc_in = dy_ff * cos_ff;

   // the half-pixel rounding offset is folded into the centre offset
   assign x_sum_in = SUMW'(p_xc_ff) + SUMW'(p_ys_ff)
                   + $signed(SUMW'({sw_sat, {TRIG_FRAC_BITS{1'b0}}}));
   assign y_sum_in = SUMW'(p_yc_ff) - SUMW'(p_xs_ff)
                   + $signed(SUMW'({sh_sat, {TRIG_FRAC_BITS{1'b0}}}));

   logic [IXW-1:0] ix;
   logic [IXW-1:0] iy;
   logic           x_hit;
   logic           y_hit;

   assign ix    = x_sum_ff[SUMW-2:TRIG_FRAC_BITS+1];
   assign iy    = y_sum_ff[SUMW-2:TRIG_FRAC_BITS+1];
   assign x_hit = (x_sum_ff > 0) && (ix < IXW'(sw_sat));
   assign y_hit = (y_sum_ff > 0) && (iy < IXW'(sh_sat));
   assign outside_in = !(x_hit && y_hit);

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      p_xc_ff  <= p_xc_in;
      p_ys_ff  <= p_ys_in;
      p_xs_ff  <= p_xs_in;
      p_yc_ff  <= p_yc_in;
      x_sum_ff <= x_sum_in;
      y_sum_ff <= y_sum_in;
   end

   // pixel memory
   logic                  ram_wr_en;
   logic [2*AB-1:0]       ram_wr_addr;
   logic                  ram_rd_en;
   logic [2*AB-1:0]       ram_rd_addr;
   logic [PIX_W-1:0]      ram_rd_data;

   assign ram_wr_addr = {AB'(req_row), AB'(req_col)};
   assign ram_rd_addr = {AB'(iy), AB'(ix)};

   nnr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_pix),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // control
   nnr_state_type    state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pix_ff;
   logic             rsp_out_ff;
   logic             rsp_load;
   logic             req_take;
   logic             load_ok;

   assign req_take = req_tvalid && req_tready;
   assign load_ok  = (req_col < MAX_SRC_SIDE) && (req_row < MAX_SRC_SIDE);

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         NNR_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[0] == OP_FETCH) begin
                  state_in = NNR_MUL;
               end else begin
                  ram_wr_en = load_ok;
               end
            end
         end
         NNR_MUL: begin
            state_in = NNR_SUM;
         end
         NNR_SUM: begin
            state_in = NNR_CHECK;
         end
         NNR_CHECK: begin
            ram_rd_en = !outside_in;
            state_in  = NNR_READ;
         end
         NNR_READ: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = NNR_IDLE;
            end
         end
         default: state_in = NNR_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= NNR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == NNR_CHECK) begin
         outside_ff <= outside_in;
      end
      if (rsp_load) begin
         rsp_out_ff <= outside_ff;
         rsp_pix_ff <= outside_ff ? {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL} : ram_rd_data;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pix_ff;
   assign rsp_tuser[0] = rsp_out_ff;

   // checks
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == NNR_READ))
      else $error("response raised outside the delivery step");

   a_outside_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_out_ff) |-> (rsp_pix_ff == {PIX_W{1'b1}}))
      else $error("outside response is not white");

   a_fetch_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser[0] == OP_FETCH) |=> (state_ff == NNR_MUL))
      else $error("fetch transaction did not start the multiply step");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == NNR_READ && rsp_valid_ff && !rsp_tready) |=>
         (state_ff == NNR_READ && rsp_valid_ff))
      else $error("pending fetch lost while the receiver stalls");

endmodule

`default_nettype wire

>>> hw/rtl/nnr_ram.sv
// ---------------------------------------------------------------------------
// nnr_ram: generic simple dual-port ram
// One write port and one read port, read data registered, held while the
// read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module nnr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> bench/tb_nearest_neighbor_image_rotator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_neighbor_image_rotator_core: testbench of the image rotator core
// Loads source pixels and fetches rotated output pixels under many register
// settings, with random stalls on both streams. A model of the inverse
// rotation kept in the bench predicts the pixel and outside flag of every
// response, and the source image is filled so that no fetch reads a pixel
// that was never loaded.
// ---------------------------------------------------------------------------
module tb_nearest_neighbor_image_rotator_core
   import nnr_pkg::*;
();

   localparam int SRC_SIDE      = 256;
   localparam int DST_SIDE      = 512;
   localparam int FRAC          = 15;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_SHOWN     = 10;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       outside;
   } rot_pixel_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // col [8:0], row [17:9], blue_in [25:18], green_in [33:26], red_in [41:34]
   logic [47:0]           req_tdata  = '0;
   // opcode [0]
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // blue_out [7:0], green_out [15:8], red_out [23:16]
   logic [23:0]           rsp_tdata;
   // outside [0]
   logic [0:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // register copies and source image as the block should hold them
   logic [ROT_W-1:0]     rot_deg;
   logic [SRC_REG_W-1:0] src_w;
   logic [SRC_REG_W-1:0] src_h;
   logic [DST_REG_W-1:0] dst_w;
   logic [DST_REG_W-1:0] dst_h;
   logic [23:0]          src_image  [0:SRC_SIDE*SRC_SIDE-1];
   bit                   src_loaded [0:SRC_SIDE*SRC_SIDE-1];
   longint               quarter_wave [0:90];
   rot_pixel_type        expected_pixels [$];

   int error_count     = 0;
   bit req_steady      = 1'b0;
   bit rsp_steady      = 1'b0;
   int rsp_hold_cycles = 0;

   nearest_neighbor_image_rotator_core #(
      .MAX_SRC_SIDE   (SRC_SIDE),
      .MAX_DST_SIDE   (DST_SIDE),
      .TRIG_FRAC_BITS (FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // q30 taylor series of sin, rounded to q15; odd terms subtract
   function automatic longint q15_sine_of_degree(input int deg);
      longint unsigned k;
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned pos_sum;
      longint unsigned neg_sum;
      longint unsigned v;
      k = deg;
      ang = (k * PI_Q30 + 64'd90) / 64'd180;
      ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
      term = ang;
      pos_sum = ang;
      neg_sum = 0;
      for (int n = 1; n <= 12; n++) begin
         k = 4 * n * n + 2 * n;
         term = ((term * ang_sq + (64'd1 << 29)) >> 30) / k;
         if (n % 2 == 1) begin
            neg_sum += term;
         end else begin
            pos_sum += term;
         end
      end
      v = (neg_sum > pos_sum) ? 64'd0 : pos_sum - neg_sum;
      return longint'((v + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
   endfunction

   function automatic longint sine_deg(input int a);
      int r;
      r = a % 360;
      if (r <= 90) return quarter_wave[r];
      if (r <= 180) return quarter_wave[180 - r];
      if (r <= 270) return -quarter_wave[r - 180];
      return -quarter_wave[360 - r];
   endfunction

   // half-pixel fixed point to pixel index, halves away from zero
   function automatic longint round_to_pixel(input longint v);
      longint half;
      half = longint'(1) << FRAC;
      if (v >= 0) return (v + half) >>> (FRAC + 1);
      return -((-v + half) >>> (FRAC + 1));
   endfunction

   function automatic void map_to_source(input logic [8:0] col, input logic [8:0] row,
                                         output longint ix, output longint iy,
                                         output bit in_src);
      longint sw, sh, dw, dh, cl, rw, dx, dy, s, c;
      sw = (src_w > SRC_SIDE) ? SRC_SIDE : src_w;
      sh = (src_h > SRC_SIDE) ? SRC_SIDE : src_h;
      dw = (dst_w > DST_SIDE) ? DST_SIDE : dst_w;
      dh = (dst_h > DST_SIDE) ? DST_SIDE : dst_h;
      cl = col;
      rw = row;
      s = sine_deg(int'(rot_deg));
      c = sine_deg(int'(rot_deg) + 90);
      dx = 2 * cl - (dw - 1);
      dy = 2 * rw - (dh - 1);
      ix = round_to_pixel(dx * c + dy * s + (sw - 1) * (longint'(1) << FRAC));
      iy = round_to_pixel(-dx * s + dy * c + (sh - 1) * (longint'(1) << FRAC));
      in_src = (ix >= 0) && (ix <= sw - 1) && (iy >= 0) && (iy <= sh - 1);
   endfunction

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // valid stays high across back-to-back transactions
   task automatic send_item(input nnr_op_type op, input logic [8:0] col,
                            input logic [8:0] row, input logic [23:0] pix);
      int gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, pix, row, col};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_pixel(input int col, input int row, input logic [23:0] pix);
      send_item(OP_LOAD, col[8:0], row[8:0], pix);
      if (col < SRC_SIDE && row < SRC_SIDE) begin
         src_image[row * SRC_SIDE + col] = pix;
         src_loaded[row * SRC_SIDE + col] = 1'b1;
      end
   endtask

   task automatic fetch_pixel(input int col, input int row);
      longint        ix;
      longint        iy;
      bit            in_src;
      int            addr;
      rot_pixel_type want;
      map_to_source(col[8:0], row[8:0], ix, iy, in_src);
      if (in_src) begin
         addr = int'(iy) * SRC_SIDE + int'(ix);
         // the mapped pixel must hold loaded data before it is fetched
         if (!src_loaded[addr]) begin
            load_pixel(int'(ix), int'(iy), 24'($urandom));
         end
         want.blue    = src_image[addr][7:0];
         want.green   = src_image[addr][15:8];
         want.red     = src_image[addr][23:16];
         want.outside = 1'b0;
      end else begin
         want.blue    = WHITE_LEVEL;
         want.green   = WHITE_LEVEL;
         want.red     = WHITE_LEVEL;
         want.outside = 1'b1;
      end
      send_item(OP_FETCH, col[8:0], row[8:0], 24'($urandom));
      expected_pixels.push_back(want);
   endtask

   task automatic wait_for_idle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input int idx, input int value);
      logic [CSR_DATA_W-1:0] wd;
      wd = CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= wd;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (CSR_IDX_W'(idx))
         CSR_ROTATION:   rot_deg = wd[ROT_W-1:0];
         CSR_SRC_WIDTH:  src_w = wd[SRC_REG_W-1:0];
         CSR_SRC_HEIGHT: src_h = wd[SRC_REG_W-1:0];
         CSR_DST_WIDTH:  dst_w = wd[DST_REG_W-1:0];
         CSR_DST_HEIGHT: dst_h = wd[DST_REG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input int rot, input int sw, input int sh,
                            input int dw, input int dh);
      wait_for_idle();
      write_csr(CSR_ROTATION, rot);
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      write_csr(CSR_DST_WIDTH, dw);
      write_csr(CSR_DST_HEIGHT, dh);
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   initial begin : response_sink
      int stall;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = pick_gap(rsp_steady);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_SHOWN) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : response_check
      rot_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $display("%0t: response with none expected, pixel %h outside %b",
                        $time, rsp_tdata, rsp_tuser);
            end
         end else begin
            want = expected_pixels.pop_front();
            check_field("blue", want.blue, rsp_tdata[7:0]);
            check_field("green", want.green, rsp_tdata[15:8]);
            check_field("red", want.red, rsp_tdata[23:16]);
            check_field("outside", {7'b0, want.outside}, {7'b0, rsp_tuser[0]});
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset values: no rotation, 256x256 onto 256x256, every point maps to itself
   task automatic test_identity_load_fetch();
      load_pixel(0, 0, 24'h000000);
      load_pixel(255, 255, 24'hFFFFFF);
      load_pixel(255, 0, 24'h5AA50F);
      load_pixel(0, 255, 24'hA55AF0);
      // off the store, must be dropped
      load_pixel(256, 7, 24'h123456);
      load_pixel(511, 511, 24'h654321);
      fetch_pixel(0, 0);
      fetch_pixel(255, 255);
      fetch_pixel(255, 0);
      fetch_pixel(0, 255);
      fetch_pixel(256, 7);
      fetch_pixel(511, 511);
   endtask

   task automatic test_register_extremes();
      configure(0, 1, 1, 1, 1);
      fetch_pixel(0, 0);
      fetch_pixel(1, 0);
      // zero source size: everything lands outside
      configure(90, 0, 0, 4, 4);
      fetch_pixel(0, 0);
      fetch_pixel(3, 3);
      // angles past 359 wrap
      configure(360, 5, 3, 7, 5);
      fetch_pixel(0, 0);
      fetch_pixel(6, 4);
      configure(511, 5, 3, 7, 5);
      fetch_pixel(3, 2);
      configure(359, 6, 6, 6, 6);
      fetch_pixel(0, 5);
      configure(180, 6, 4, 6, 4);
      fetch_pixel(0, 0);
      configure(270, 6, 4, 4, 6);
      fetch_pixel(3, 5);
      // oversized sizes saturate
      configure(45, 511, 511, 1023, 1023);
      fetch_pixel(0, 0);
      fetch_pixel(511, 511);
      fetch_pixel(255, 256);
      // writes to unused indexes change nothing
      wait_for_idle();
      for (int i = int'(CSR_DST_HEIGHT) + 1; i < (1 << CSR_IDX_W); i++) begin
         write_csr(i, $urandom_range(1023));
      end
      fetch_pixel(300, 200);
   endtask

   // long receiver stall with the sender still offering: the core must back up
   task automatic test_output_backpressure();
      configure(30, 8, 8, 12, 12);
      req_steady = 1'b1;
      rsp_hold_cycles = 200;
      repeat (16) fetch_pixel($urandom_range(11), $urandom_range(11));
      req_steady = 1'b0;
   endtask

   task automatic test_random_rotations(input int phases, input int per_phase);
      int rot, sw, sh, dw, dh, sel, r, swe, she, dwe, dhe;
      for (int p = 0; p < phases; p++) begin
         sel = $urandom_range(9);
         rot = $urandom_range(511);
         if (sel < 6) begin
            sw = $urandom_range(20, 1);
            sh = $urandom_range(20, 1);
            dw = sw + $urandom_range(12);
            dh = sh + $urandom_range(12);
         end else if (sel < 8) begin
            sw = $urandom_range(64, 20);
            sh = $urandom_range(64, 20);
            dw = sw + $urandom_range(40);
            dh = sh + $urandom_range(40);
         end else begin
            rot = $urandom_range(1023);
            sw = $urandom_range(1023);
            sh = $urandom_range(1023);
            dw = $urandom_range(1023);
            dh = $urandom_range(1023);
         end
         if ($urandom_range(3) == 0) rot = 90 * $urandom_range(3);
         configure(rot, sw, sh, dw, dh);
         swe = (src_w > SRC_SIDE) ? SRC_SIDE : int'(src_w);
         she = (src_h > SRC_SIDE) ? SRC_SIDE : int'(src_h);
         dwe = (dst_w > DST_SIDE) ? DST_SIDE : int'(dst_w);
         dhe = (dst_h > DST_SIDE) ? DST_SIDE : int'(dst_h);
         if (swe == 0) swe = 1;
         if (she == 0) she = 1;
         if (dwe == 0) dwe = 1;
         if (dhe == 0) dhe = 1;
         req_steady = (p % 4 == 1) || (p % 4 == 3);
         rsp_steady = (p % 4 == 2) || (p % 4 == 3);
         // paint part of the source first, then a fetch-heavy mix
         repeat (per_phase / 4) begin
            load_pixel($urandom_range(swe - 1), $urandom_range(she - 1), 24'($urandom));
         end
         repeat (per_phase - per_phase / 4) begin
            r = $urandom_range(99);
            if (r < 70) begin
               fetch_pixel($urandom_range(dwe - 1), $urandom_range(dhe - 1));
            end else if (r < 80) begin
               fetch_pixel($urandom_range(511), $urandom_range(511));
            end else if (r < 92) begin
               load_pixel($urandom_range(swe - 1), $urandom_range(she - 1), 24'($urandom));
            end else begin
               load_pixel($urandom_range(511), $urandom_range(511), 24'($urandom));
            end
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin : test_sequence
      for (int k = 0; k <= 90; k++) quarter_wave[k] = q15_sine_of_degree(k);
      rot_deg = '0;
      src_w   = 9'd256;
      src_h   = 9'd256;
      dst_w   = 10'd256;
      dst_h   = 10'd256;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_load_fetch();
      test_register_extremes();
      test_output_backpressure();
      test_random_rotations(10, 140);

      wait_for_idle();
      if (expected_pixels.size() != 0) begin
         $display("%0d expected responses never arrived", expected_pixels.size());
         error_count += expected_pixels.size();
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
